FILE: design/triangle_submerged_area_core_macros.svh
// Assertion helpers for the block that checks itself.
`ifndef TRIANGLE_SUBMERGED_AREA_CORE_MACROS_SVH
`define TRIANGLE_SUBMERGED_AREA_CORE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define TSA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define TSA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tsa_pkg.sv
package tsa_pkg;

    localparam int COORD_W  = 16;
    localparam int EDGE_W   = 17;
    localparam int PROD_W   = 34;
    localparam int CROSS_W  = 35;
    localparam int CMAG_W   = 34;
    localparam int HALF_W   = 17;
    localparam int NORM_W   = 68;
    localparam int ROOT_W   = 35;
    localparam int WT_W     = 16;
    localparam int AREA_W   = 32;
    localparam int MUL_W    = ROOT_W + WT_W;
    localparam int VERT_W   = 3 * COORD_W;
    localparam int IN_W     = 3 * VERT_W + 3 * COORD_W + AREA_W;

    localparam int COORD_FRAC_BITS_DEF = 12;
    localparam int AREA_FRAC_BITS_DEF  = 24;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ALL  = 2'd1,
        KIND_ONE  = 2'd2,
        KIND_TWO  = 2'd3
    } t_kind;

    // Data that rides along the arithmetic pipeline.
    typedef struct packed {
        t_kind             kind;
        logic [WT_W-1:0]   n1;
        logic [WT_W-1:0]   d1;
        logic [WT_W-1:0]   n2;
        logic [WT_W-1:0]   d2;
        logic [AREA_W-1:0] full;
    } t_side;

    localparam int SIDE_W = $bits(t_side);

endpackage

FILE: design/tsa_cross.sv
module tsa_cross (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [tsa_pkg::VERT_W-1:0]    i_vertex_a,
    input  logic [tsa_pkg::VERT_W-1:0]    i_vertex_b,
    input  logic [tsa_pkg::VERT_W-1:0]    i_vertex_c,
    input  logic signed [tsa_pkg::COORD_W-1:0] i_depth_a,
    input  logic signed [tsa_pkg::COORD_W-1:0] i_depth_b,
    input  logic signed [tsa_pkg::COORD_W-1:0] i_depth_c,
    input  logic [tsa_pkg::AREA_W-1:0]    i_full_area,
    output logic                          o_valid,
    output logic [tsa_pkg::CMAG_W-1:0]    o_mag [3],
    output tsa_pkg::t_side                o_side
);
    import tsa_pkg::*;

    logic signed [COORD_W-1:0] w_p [3][3];
    logic signed [COORD_W-1:0] w_d [3];
    logic [2:0]                w_wet;
    logic [1:0]                w_cnt;
    logic [1:0]                w_odd, w_o1, w_o2;
    logic [WT_W-1:0]           w_mag [3];
    t_side                     n_side;

    logic signed [EDGE_W-1:0]  r_e1 [3];
    logic signed [EDGE_W-1:0]  r_e2 [3];
    logic signed [PROD_W-1:0]  r_pa [3];
    logic signed [PROD_W-1:0]  r_pb [3];
    logic [CMAG_W-1:0]         r_mag [3];
    t_side                     r_side [3];
    logic [2:0]                r_vld;

    // Unpack and classify vertices
    always_comb begin
        w_d[0] = i_depth_a;
        w_d[1] = i_depth_b;
        w_d[2] = i_depth_c;
        for (int k = 0; k < 3; k++) begin
            w_p[0][k] = i_vertex_a[k*COORD_W +: COORD_W];
            w_p[1][k] = i_vertex_b[k*COORD_W +: COORD_W];
            w_p[2][k] = i_vertex_c[k*COORD_W +: COORD_W];
        end
        for (int v = 0; v < 3; v++) begin
            w_wet[v] = !w_d[v][COORD_W-1];
            w_mag[v] = w_d[v][COORD_W-1] ? WT_W'(-w_d[v]) : WT_W'(w_d[v]);
        end
        w_cnt = 2'(w_wet[0]) + 2'(w_wet[1]) + 2'(w_wet[2]);
        // Odd vertex: the lone wet one (one wet) or the lone dry one (two wet)
        if ((w_cnt == 2'd1) ? w_wet[0] : !w_wet[0]) begin
            w_odd = 2'd0;
        end else if ((w_cnt == 2'd1) ? w_wet[1] : !w_wet[1]) begin
            w_odd = 2'd1;
        end else begin
            w_odd = 2'd2;
        end
        w_o1 = (w_odd == 2'd0) ? 2'd1 : 2'd0;
        w_o2 = (w_odd == 2'd2) ? 2'd1 : 2'd2;

        n_side.full = i_full_area;
        case (w_cnt)
            2'd0:    n_side.kind = KIND_NONE;
            2'd1:    n_side.kind = KIND_ONE;
            2'd2:    n_side.kind = KIND_TWO;
            default: n_side.kind = KIND_ALL;
        endcase
        // Weights: odd vertex depth magnitude over that plus the other vertex's magnitude
        n_side.n1 = w_mag[w_odd];
        n_side.n2 = w_mag[w_odd];
        n_side.d1 = w_mag[w_odd] + w_mag[w_o1];
        n_side.d2 = w_mag[w_odd] + w_mag[w_o2];
    end

    // Stage 1: edges from the odd vertex
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= EDGE_W'(w_p[w_o1][k]) - EDGE_W'(w_p[w_odd][k]);
                r_e2[k] <= EDGE_W'(w_p[w_o2][k]) - EDGE_W'(w_p[w_odd][k]);
            end
            r_side[0] <= n_side;
        end
    end

    // Stage 2: cross product terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa[0] <= r_e1[1] * r_e2[2];
            r_pb[0] <= r_e1[2] * r_e2[1];
            r_pa[1] <= r_e1[2] * r_e2[0];
            r_pb[1] <= r_e1[0] * r_e2[2];
            r_pa[2] <= r_e1[0] * r_e2[1];
            r_pb[2] <= r_e1[1] * r_e2[0];
            r_side[1] <= r_side[0];
        end
    end

    // Stage 3: component magnitudes
    always_ff @(posedge i_clk) begin
        logic signed [CROSS_W-1:0] c;
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                c = CROSS_W'(r_pa[k]) - CROSS_W'(r_pb[k]);
                r_mag[k] <= c[CROSS_W-1] ? CMAG_W'(-c) : CMAG_W'(c);
            end
            r_side[2] <= r_side[1];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign o_valid = r_vld[2];
    assign o_mag   = r_mag;
    assign o_side  = r_side[2];

endmodule

FILE: design/tsa_norm.sv
module tsa_norm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [tsa_pkg::CMAG_W-1:0]  i_mag [3],
    input  tsa_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [tsa_pkg::NORM_W-1:0]  o_norm,
    output tsa_pkg::t_side              o_side
);
    import tsa_pkg::*;

    logic [2*HALF_W-1:0] r_hh [3];
    logic [2*HALF_W-1:0] r_hl [3];
    logic [2*HALF_W-1:0] r_ll [3];
    logic [NORM_W-1:0]   r_sq [3];
    logic [NORM_W-1:0]   r_norm;
    t_side               r_side [3];
    logic [2:0]          r_vld;

    // Stage 4: split squares into 17-bit partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_hh[k] <= i_mag[k][CMAG_W-1:HALF_W] * i_mag[k][CMAG_W-1:HALF_W];
                r_hl[k] <= i_mag[k][CMAG_W-1:HALF_W] * i_mag[k][HALF_W-1:0];
                r_ll[k] <= i_mag[k][HALF_W-1:0] * i_mag[k][HALF_W-1:0];
            end
            r_side[0] <= i_side;
        end
    end

    // Stage 5: assemble each square
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= (NORM_W'(r_hh[k]) << (2*HALF_W))
                         + (NORM_W'(r_hl[k]) << (HALF_W+1))
                         + NORM_W'(r_ll[k]);
            end
            r_side[1] <= r_side[0];
        end
    end

    // Stage 6: squared length
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm    <= r_sq[0] + r_sq[1] + r_sq[2];
            r_side[2] <= r_side[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign o_valid = r_vld[2];
    assign o_norm  = r_norm;
    assign o_side  = r_side[2];

endmodule

FILE: design/tsa_sqrt.sv
module tsa_sqrt #(
    parameter int SW = tsa_pkg::SIDE_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [tsa_pkg::NORM_W-1:0]  i_norm,
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    output logic [tsa_pkg::ROOT_W-1:0]  o_root,
    output logic [SW-1:0]               o_side
);
    import tsa_pkg::*;

    localparam int TW = 2*ROOT_W + 1;

    logic [NORM_W-1:0] r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SW-1:0]     r_side [ROOT_W];
    logic [ROOT_W-1:0] r_vld;

    // One root bit per stage, most significant first
    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int B = ROOT_W - 1 - s;
        logic [NORM_W-1:0] w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [SW-1:0]     w_side;
        logic              w_vld;
        logic [TW-1:0]     w_try;
        logic              w_take;

        if (s == 0) begin : g_head
            assign w_rem  = i_norm;
            assign w_root = '0;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_body
            assign w_rem  = r_rem[s-1];
            assign w_root = r_root[s-1];
            assign w_side = r_side[s-1];
            assign w_vld  = r_vld[s-1];
        end

        // (root + 2^B)^2 - root^2
        assign w_try  = (TW'(w_root) << (B+1)) + (TW'(1) << (2*B));
        assign w_take = TW'(w_rem) >= w_try;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_take ? (w_rem - w_try[NORM_W-1:0]) : w_rem;
                r_root[s] <= w_root | (ROOT_W'(w_take) << B);
                r_side[s] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

FILE: design/tsa_div.sv
module tsa_div #(
    parameter int QW = tsa_pkg::ROOT_W,
    parameter int DW = tsa_pkg::WT_W,
    parameter int SW = tsa_pkg::SIDE_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [QW+DW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [QW-1:0]    o_quot,
    output logic [SW-1:0]    o_side
);
    // The quotient is known to fit QW bits, so the top DW numerator
    // bits start as the remainder.
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_work [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] r_vld;

    // Restoring division, one quotient bit per stage
    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_work;
        logic [DW-1:0] w_den;
        logic [SW-1:0] w_side;
        logic          w_vld;
        logic [DW:0]   w_try;
        logic          w_take;
        logic [DW:0]   w_diff;

        if (s == 0) begin : g_head
            assign w_rem  = i_num[QW+DW-1:QW];
            assign w_work = i_num[QW-1:0];
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_body
            assign w_rem  = r_rem[s-1];
            assign w_work = r_work[s-1];
            assign w_den  = r_den[s-1];
            assign w_side = r_side[s-1];
            assign w_vld  = r_vld[s-1];
        end

        assign w_try  = {w_rem, w_work[QW-1]};
        assign w_take = w_try >= {1'b0, w_den};
        assign w_diff = w_try - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_take ? w_diff[DW-1:0] : w_try[DW-1:0];
                r_work[s] <= {w_work[QW-2:0], w_take};
                r_den[s]  <= w_den;
                r_side[s] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_work[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

FILE: design/triangle_submerged_area_core.sv
// Wetted area of one triangle cut by the waterline.
// Input stream (s_axis): one beat per triangle, tdata carries the three
// vertices, the three depths and the full area. Output stream (m_axis):
// one beat per input beat, tdata carries the wetted area, in input order.
// A depth at or above zero marks a submerged vertex. No wet vertex gives
// zero, all wet gives the full area, otherwise the cut triangle is formed
// from the cross-product length (bit-serial square root) scaled by the two
// interpolation weights (two restoring dividers, one bit per stage).
// Throughput: one triangle per cycle while not stalled. The path from
// the input beat to o_m_axis_tvalid runs through the 35-stage root and
// the two 35-stage dividers plus ten stages of multiply, add and select.
// Stall: the whole pipeline freezes while the two-entry output buffer is
// full; o_s_axis_tready comes straight from a register, so no combinational
// path runs from i_m_axis_tready to o_s_axis_tready.
// Reset (synchronous, active low) empties the pipeline and the buffer; no
// state is kept between triangles.
`include "triangle_submerged_area_core_macros.svh"

module triangle_submerged_area_core #(
    parameter int COORD_FRAC_BITS = tsa_pkg::COORD_FRAC_BITS_DEF,
    parameter int AREA_FRAC_BITS  = tsa_pkg::AREA_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // vertex_a[47:0], vertex_b[95:48], vertex_c[143:96], depth_a[159:144],
    // depth_b[175:160], depth_c[191:176], full_area[223:192]
    input  logic [tsa_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // wet_area[31:0]
    output logic [tsa_pkg::AREA_W-1:0] o_m_axis_tdata
);
    import tsa_pkg::*;

    localparam int SHIFT_SRC = 2*COORD_FRAC_BITS + 1;
    localparam int RSH = (SHIFT_SRC >= AREA_FRAC_BITS) ? SHIFT_SRC - AREA_FRAC_BITS : 0;
    localparam int LSH = (SHIFT_SRC >= AREA_FRAC_BITS) ? 0 : AREA_FRAC_BITS - SHIFT_SRC;
    localparam int WIDE_W = 64;

    logic              w_en;
    logic              w_cr_vld, w_nm_vld, w_sq_vld, w_d1_vld, w_d2_vld;
    logic [CMAG_W-1:0] w_mag [3];
    t_side             w_cr_side, w_nm_side, w_sq_side, w_d1_side, w_d2_side;
    logic [NORM_W-1:0] w_norm;
    logic [ROOT_W-1:0] w_root, w_q1, w_q2;
    logic [WIDE_W-1:0] w_scaled;
    logic [AREA_W-1:0] w_part;
    logic [AREA_W-1:0] n_area;

    logic              r_m1_vld, r_m2_vld, r_fin_valid;
    logic [MUL_W-1:0]  r_m1_prod, r_m2_prod;
    t_side             r_m1_side, r_m2_side;
    logic [AREA_W-1:0] r_fin_area;
    t_kind             r_fin_kind;
    logic              r_out_valid, r_skid_valid;
    logic [AREA_W-1:0] r_out_data, r_skid_data;

    // Pipeline advances whenever the spare buffer entry is free
    assign w_en            = !r_skid_valid;
    assign o_s_axis_tready = w_en;

    tsa_cross u_cross (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_s_axis_tvalid),
        .i_vertex_a  (i_s_axis_tdata[0 +: VERT_W]),
        .i_vertex_b  (i_s_axis_tdata[VERT_W +: VERT_W]),
        .i_vertex_c  (i_s_axis_tdata[2*VERT_W +: VERT_W]),
        .i_depth_a   (i_s_axis_tdata[3*VERT_W +: COORD_W]),
        .i_depth_b   (i_s_axis_tdata[3*VERT_W+COORD_W +: COORD_W]),
        .i_depth_c   (i_s_axis_tdata[3*VERT_W+2*COORD_W +: COORD_W]),
        .i_full_area (i_s_axis_tdata[3*VERT_W+3*COORD_W +: AREA_W]),
        .o_valid     (w_cr_vld),
        .o_mag       (w_mag),
        .o_side      (w_cr_side)
    );

    tsa_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cr_vld),
        .i_mag   (w_mag),
        .i_side  (w_cr_side),
        .o_valid (w_nm_vld),
        .o_norm  (w_norm),
        .o_side  (w_nm_side)
    );

    tsa_sqrt #(.SW(SIDE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_nm_vld),
        .i_norm  (w_norm),
        .i_side  (w_nm_side),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Scale by the first weight numerator
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_prod <= MUL_W'(w_root) * MUL_W'(w_sq_side.n1);
            r_m1_side <= w_sq_side;
        end
    end

    tsa_div #(.QW(ROOT_W), .DW(WT_W), .SW(SIDE_W)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m1_vld),
        .i_num   (r_m1_prod),
        .i_den   (r_m1_side.d1),
        .i_side  (r_m1_side),
        .o_valid (w_d1_vld),
        .o_quot  (w_q1),
        .o_side  (w_d1_side)
    );

    // Scale by the second weight numerator
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_prod <= MUL_W'(w_q1) * MUL_W'(w_d1_side.n2);
            r_m2_side <= w_d1_side;
        end
    end

    tsa_div #(.QW(ROOT_W), .DW(WT_W), .SW(SIDE_W)) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m2_vld),
        .i_num   (r_m2_prod),
        .i_den   (r_m2_side.d2),
        .i_side  (r_m2_side),
        .o_valid (w_d2_vld),
        .o_quot  (w_q2),
        .o_side  (w_d2_side)
    );

    // Halve, convert to the area format, saturate, then pick by case
    assign w_scaled = (WIDE_W'(w_q2) >> RSH) << LSH;
    assign w_part   = (|w_scaled[WIDE_W-1:AREA_W]) ? '1 : w_scaled[AREA_W-1:0];

    always_comb begin
        case (w_d2_side.kind)
            KIND_NONE: n_area = '0;
            KIND_ALL:  n_area = w_d2_side.full;
            KIND_ONE:  n_area = w_part;
            KIND_TWO:  n_area = (w_part >= w_d2_side.full) ? '0 : w_d2_side.full - w_part;
            default:   n_area = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin_area <= n_area;
            r_fin_kind <= w_d2_side.kind;
        end
    end

    // Valid bits of the stages kept here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld    <= 1'b0;
            r_m2_vld    <= 1'b0;
            r_fin_valid <= 1'b0;
        end else if (w_en) begin
            r_m1_vld    <= w_sq_vld;
            r_m2_vld    <= w_d1_vld;
            r_fin_valid <= w_d2_vld;
        end
    end

    // Output register with one spare entry to absorb a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_m_axis_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_fin_valid;
                r_out_data  <= r_fin_area;
            end
        end else if (r_fin_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= r_fin_area;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `TSA_ASSERT_IMP(a_skid_only_behind_out, r_skid_valid, r_out_valid, "spare entry full while output empty")
    `TSA_ASSERT_NXT(a_skid_catches_stall, r_fin_valid && w_en && r_out_valid && !i_m_axis_tready, r_skid_valid, "beat dropped on output stall")
    `TSA_ASSERT_IMP(a_dry_gives_zero, r_fin_valid && (r_fin_kind == KIND_NONE), r_fin_area == '0, "fully dry triangle with nonzero area")

endmodule

FILE: test/triangle_submerged_area_core_tb.sv
module triangle_submerged_area_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsa_pkg::*;

    localparam int CFRAC = 12;
    localparam int AFRAC = 24;
    localparam int LATENCY = 115;

    typedef longint signed t_vec[3];

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    // vertex_a, vertex_b, vertex_c, depth_a, depth_b, depth_c, full_area
    logic [IN_W-1:0]    i_s_axis_tdata = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    // wet_area
    logic [AREA_W-1:0]  o_m_axis_tdata;

    triangle_submerged_area_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // Floor of the length of cross(e1, e2), all integer
    function automatic longint unsigned cross_length(t_vec e1, t_vec e2);
        longint signed c[3];
        longint unsigned m;
        logic [127:0] norm;
        logic [127:0] sq;
        logic [63:0] root;
        logic [63:0] cand;
        norm = '0;
        root = '0;
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int i = 0; i < 3; i++) begin
            m = c[i] < 0 ? longint'(-c[i]) : c[i];
            norm += 128'(m) * 128'(m);
        end
        for (int b = 39; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            sq = 128'(cand) * 128'(cand);
            if (sq <= norm) root = cand;
        end
        return root;
    endfunction

    // Area of the triangle cut from base toward p1 and p2 by two weights
    function automatic logic [31:0] cut_area(t_vec base, t_vec p1, t_vec p2,
                                             longint unsigned n1, longint unsigned d1,
                                             longint unsigned n2, longint unsigned d2);
        t_vec e1;
        t_vec e2;
        longint unsigned q;
        for (int i = 0; i < 3; i++) begin
            e1[i] = p1[i] - base[i];
            e2[i] = p2[i] - base[i];
        end
        q = cross_length(e1, e2);
        q = q * n1 / d1;
        q = q * n2 / d2;
        if (2 * CFRAC + 1 >= AFRAC) q = q >> (2 * CFRAC + 1 - AFRAC);
        else q = q << (AFRAC - 2 * CFRAC - 1);
        return q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    class wet_area_board;
        logic [31:0] expected_q[$];
        int errors;
        int checked;
        int kind_seen[4];

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        function void note_triangle(logic [IN_W-1:0] beat);
            t_vec p[3];
            longint signed dep[3];
            longint unsigned full, mag_odd, dry;
            int cnt, odd, o1, o2;
            logic [31:0] res;
            logic [47:0] v;
            cnt = 0;
            odd = 0;
            full = beat[223:192];
            for (int i = 0; i < 3; i++) begin
                v = beat[48*i +: 48];
                for (int k = 0; k < 3; k++) p[i][k] = $signed(v[16*k +: 16]);
                dep[i] = $signed(beat[144 + 16*i +: 16]);
                if (dep[i] >= 0) cnt++;
            end
            if (cnt == 0) begin
                res = '0;
                kind_seen[KIND_NONE]++;
            end else if (cnt == 3) begin
                res = full[31:0];
                kind_seen[KIND_ALL]++;
            end else begin
                // find the lone wet vertex (one wet) or lone dry vertex (two wet)
                for (int i = 2; i >= 0; i--)
                    if ((dep[i] >= 0) == (cnt == 1)) odd = i;
                o1 = odd == 0 ? 1 : 0;
                o2 = odd == 2 ? 1 : 2;
                if (cnt == 1) begin
                    kind_seen[KIND_ONE]++;
                    res = cut_area(p[odd], p[o1], p[o2],
                                   dep[odd], dep[odd] - dep[o1],
                                   dep[odd], dep[odd] - dep[o2]);
                end else begin
                    kind_seen[KIND_TWO]++;
                    mag_odd = -dep[odd];
                    dry = cut_area(p[odd], p[o1], p[o2],
                                   mag_odd, dep[o1] + mag_odd,
                                   mag_odd, dep[o2] + mag_odd);
                    res = dry >= full ? 32'd0 : 32'(full - dry);
                end
            end
            expected_q = {expected_q, res};
        endfunction

        task check_area(logic [31:0] got);
            logic [31:0] want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected beat wet_area=%h", got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got !== want)
                report($sformatf("wet_area got %h want %h", got, want));
        endtask
    endclass

    wet_area_board board = new();
    bit sink_free_run = 1'b0;
    int sent = 0;

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_triangle(logic [IN_W-1:0] beat, bit no_gap);
        int g;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = beat;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_triangle(beat);
        sent++;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata = {$urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom};
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [IN_W-1:0] pack_tri(logic [47:0] va, logic [47:0] vb,
                                                logic [47:0] vc, logic [15:0] da,
                                                logic [15:0] db, logic [15:0] dc,
                                                logic [31:0] full);
        return {full, dc, db, da, vc, vb, va};
    endfunction

    function automatic logic [47:0] rand_vertex(bit narrow);
        logic [47:0] v;
        v = {$urandom, $urandom};
        if (narrow)
            for (int k = 0; k < 3; k++)
                v[16*k +: 16] = 16'($signed($urandom_range(0, 8191)) - 4096);
        return v;
    endfunction

    function automatic logic [15:0] rand_depth(bit wet);
        int r;
        r = $urandom_range(0, 9);
        if (wet) return r < 2 ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 32767));
        return r < 2 ? 16'(-$urandom_range(1, 3)) : 16'(-$urandom_range(1, 32768));
    endfunction

    // Output side: bursts of ready with stalls in between
    initial begin
        int n;
        forever begin
            n = $urandom_range(1, 30);
            repeat (n) begin
                @(negedge i_clk);
                i_m_axis_tready = 1'b1;
            end
            if (!sink_free_run) begin
                n = gap_len();
                repeat (n) begin
                    @(negedge i_clk);
                    i_m_axis_tready = 1'b0;
                end
            end
        end
    end

    // Compare every accepted result beat
    always @(posedge i_clk)
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) board.check_area(o_m_axis_tdata);

    initial begin
        #5ms;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [47:0] vmax;
        logic [47:0] vmin;
        logic [47:0] v0;
        logic [47:0] vx;
        logic [47:0] vy;
        bit no_gap;
        int mode;
        vmax = {3{16'h7FFF}};
        vmin = {3{16'h8000}};
        v0 = '0;
        vx = {16'h0000, 16'h0000, 16'h1000};
        vy = {16'h0000, 16'h1000, 16'h0000};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every wet count, each vertex in the odd role, extremes
        send_triangle(pack_tri(vx, vy, v0, 16'hFFFF, 16'h8000, 16'hF000, 32'hFFFF_FFFF), 0);
        send_triangle(pack_tri(vx, vy, v0, 16'h0000, 16'h7FFF, 16'h0001, 32'hFFFF_FFFF), 0);
        send_triangle(pack_tri(vx, vy, v0, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000), 0);
        send_triangle(pack_tri(v0, vx, vy, 16'h1000, 16'hF000, 16'hF000, 32'h0080_0000), 0);
        send_triangle(pack_tri(v0, vx, vy, 16'hF000, 16'h1000, 16'hF000, 32'h0080_0000), 0);
        send_triangle(pack_tri(v0, vx, vy, 16'hF000, 16'hF000, 16'h1000, 32'h0080_0000), 0);
        send_triangle(pack_tri(v0, vx, vy, 16'hF000, 16'h1000, 16'h1000, 32'h0080_0000), 0);
        send_triangle(pack_tri(v0, vx, vy, 16'h1000, 16'hF000, 16'h1000, 32'h0080_0000), 0);
        send_triangle(pack_tri(v0, vx, vy, 16'h1000, 16'h1000, 16'hF000, 32'h0080_0000), 0);
        // wet vertex at exactly zero depth
        send_triangle(pack_tri(v0, vx, vy, 16'h0000, 16'hF000, 16'h8000, 32'h0080_0000), 0);
        // dry part larger than the full area
        send_triangle(pack_tri(vmin, vmax, vx, 16'h7FFF, 16'h7FFF, 16'h8000, 32'h0000_0010), 0);
        send_triangle(pack_tri(v0, vx, vy, 16'hFFFF, 16'h7FFF, 16'h7FFF, 32'h0000_0000), 0);
        // huge triangle with weights near one: saturate at all ones
        send_triangle(pack_tri(vmin, vmax, {16'h8000, 16'h7FFF, 16'h8000},
                               16'h7FFF, 16'hFFFF, 16'hFFFF, 32'h0), 0);
        send_triangle(pack_tri(vmax, vmin, {16'h7FFF, 16'h8000, 16'h7FFF},
                               16'hFFFF, 16'h7FFF, 16'hFFFF, 32'h0), 0);
        send_triangle(pack_tri(vmax, vmax, vmax, 16'h7FFF, 16'h8000, 16'h8000, 32'h1234_5678), 0);
        send_triangle(pack_tri(vmin, v0, vmax, 16'h8000, 16'h8000, 16'h0000, 32'h8000_0000), 0);
        send_triangle(pack_tri(vmin, v0, vmax, 16'h7FFF, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF), 0);

        // Random: mostly partial cuts, with back-to-back stretches
        mode = 0;
        for (int i = 0; i < 1430; i++) begin
            bit w[3];
            bit narrow;
            if (i % 100 == 0) begin
                mode = $urandom_range(0, 3);
                sink_free_run = (mode == 0);
            end
            no_gap = (mode == 0);
            narrow = $urandom_range(0, 3) == 0;
            for (int k = 0; k < 3; k++) w[k] = $urandom_range(0, 1);
            send_triangle(pack_tri(rand_vertex(narrow), rand_vertex(narrow),
                                   rand_vertex(narrow), rand_depth(w[0]),
                                   rand_depth(w[1]), rand_depth(w[2]),
                                   $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 65535))
                                                            : 32'($urandom)), no_gap);
            // hold off once until the pipeline has fully drained
            if (i == 700) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
                while (board.expected_q.size() != 0) @(posedge i_clk);
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        sink_free_run = 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("covered %0d triangles, %0d results checked", sent, board.checked);
        $display("dry %0d, all wet %0d, one wet %0d, two wet %0d",
                 board.kind_seen[KIND_NONE], board.kind_seen[KIND_ALL],
                 board.kind_seen[KIND_ONE], board.kind_seen[KIND_TWO]);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
